/* rtl/core/ldvn_pkg.sv */
// Shared types and constants for the light direction view normalize block.
// Used by every module under rtl/core except ldvn_checker.
package ldvn_pkg;

  localparam int MATRIX_ELEM_BITS_DEF = 16;
  localparam int ROW_W  = 48;
  localparam int MAG_W  = 24;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int RHS_W  = SQ_W + 14;
  localparam int R_W    = 7;
  localparam int RSQ_W  = 14;
  localparam int CMP_W  = 64;
  localparam int HALF_W = 25;
  localparam int PP_W   = RSQ_W + HALF_W;
  localparam int OUT_LEN  = 120;
  localparam int LEN_SQ   = 14400;
  localparam int ITER_N   = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 2'd2;

  localparam logic [ROW_W-1:0] ROW0_RST = 48'd16384;
  localparam logic [ROW_W-1:0] ROW1_RST = 48'd1073741824;
  localparam logic [ROW_W-1:0] ROW2_RST = 48'd70368744177664;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       xf;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] dz;
  } light_t;

  typedef struct packed {
    light_t                      lt;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
  } mid_t;

endpackage

/* rtl/core/light_dir_view_normalize_top.sv */
// Throughput: one light per cycle; the whole pipeline advances on one enable,
// held while a result waits at the output register.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
// identity matrix into the three view rows.
module light_dir_view_normalize_top #(
  parameter int MATRIX_ELEM_BITS = ldvn_pkg::MATRIX_ELEM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [47:0]                     in_tdata,  // red_in, green_in, blue_in, dir_x, dir_y, dir_z
  input  logic                            in_tuser,  // transform_flag
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata,  // out_red, out_green, out_blue, out_dir_x, out_dir_y, out_dir_z
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ldvn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldvn_pkg::ROW_W-1:0]      cfg_data
);
  import ldvn_pkg::*;

  logic [ROW_W-1:0] row0_r, row1_r, row2_r;
  logic             en;
  light_t           in_lt, out_lt;
  logic             mid_v, out_v;
  mid_t             mid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= ROW0_RST;
      row1_r <= ROW1_RST;
      row2_r <= ROW2_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW0: row0_r <= cfg_data;
        REG_ROW1: row1_r <= cfg_data;
        REG_ROW2: row2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !out_v || out_tready;
  assign in_tready = en;

  assign in_lt.red   = in_tdata[7:0];
  assign in_lt.green = in_tdata[15:8];
  assign in_lt.blue  = in_tdata[23:16];
  assign in_lt.xf    = in_tuser;
  assign in_lt.dx    = in_tdata[31:24];
  assign in_lt.dy    = in_tdata[39:32];
  assign in_lt.dz    = in_tdata[47:40];

  ldvn_xform #(.MATRIX_ELEM_BITS(MATRIX_ELEM_BITS)) u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_tvalid),
    .in_lt   (in_lt),
    .row0    (row0_r),
    .row1    (row1_r),
    .row2    (row2_r),
    .out_v   (mid_v),
    .out_mid (mid)
  );

  ldvn_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (mid_v),
    .in_mid (mid),
    .out_v  (out_v),
    .out_lt (out_lt)
  );

  assign out_tvalid = out_v;
  assign out_tdata  = {out_lt.dz, out_lt.dy, out_lt.dx,
                       out_lt.blue, out_lt.green, out_lt.red};

endmodule

/* rtl/core/ldvn_xform.sv */
// Matrix product, magnitude and range scaling: four pipeline stages.
// Depends on ldvn_pkg.
module ldvn_xform #(
  parameter int MATRIX_ELEM_BITS = ldvn_pkg::MATRIX_ELEM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  ldvn_pkg::light_t            in_lt,
  input  logic [ldvn_pkg::ROW_W-1:0]  row0,
  input  logic [ldvn_pkg::ROW_W-1:0]  row1,
  input  logic [ldvn_pkg::ROW_W-1:0]  row2,
  output logic                        out_v,
  output ldvn_pkg::mid_t              out_mid
);
  import ldvn_pkg::*;

  localparam int E   = MATRIX_ELEM_BITS;
  localparam int PW  = E + 8;
  localparam int AW  = E + 10;
  localparam int SHW = $clog2(AW);

  logic [2:0][63:0]         rows_ext;
  logic [2:0][2:0][E-1:0]   ent;
  logic [2:0][7:0]          dv;

  logic                     v1_r, v2_r, v3_r, v4_r;
  light_t                   lt1_r, lt2_r, lt3_r;
  logic [2:0][2:0][PW-1:0]  prod_r;
  logic [2:0]               neg2_r, neg3_r;
  logic [2:0][AW-1:0]       mag2_r, mag3_r;
  logic [SHW-1:0]           sh3_r;
  mid_t                     mid4_r;

  logic [2:0][AW-1:0]       acc_c, mag_c;
  logic [AW-1:0]            or_c;
  logic [SHW-1:0]           msb_c, sh_c;
  logic [2:0][63:0]         shf_c;

  assign rows_ext = {{16'd0, row2}, {16'd0, row1}, {16'd0, row0}};
  assign dv = {in_lt.dz, in_lt.dy, in_lt.dx};

  for (genvar k = 0; k < 3; k++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int SH = j * E;
      if (SH < 64) begin : g_in
        logic [63:0] t;
        assign t = rows_ext[k] >> SH;
        assign ent[k][j] = t[E-1:0];
      end else begin : g_out
        assign ent[k][j] = '0;
      end
    end
  end

  always_comb begin
    or_c  = '0;
    msb_c = '0;
    for (int i = 0; i < 3; i++) begin
      acc_c[i] = AW'($signed(prod_r[0][i])) + AW'($signed(prod_r[1][i]))
               + AW'($signed(prod_r[2][i]));
      mag_c[i] = acc_c[i][AW-1] ? (~acc_c[i] + AW'(1)) : acc_c[i];
    end
    for (int i = 0; i < 3; i++) or_c = or_c | mag2_r[i];
    for (int b = 0; b < AW; b++) if (or_c[b]) msb_c = SHW'(b);
    sh_c = (msb_c > SHW'(MAG_W - 1)) ? SHW'(msb_c - SHW'(MAG_W - 1)) : '0;
    for (int i = 0; i < 3; i++) shf_c[i] = 64'(mag3_r[i]) >> sh3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lt1_r <= in_lt;
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++)
          prod_r[k][j] <= PW'($signed(dv[k]) * $signed(ent[k][j]));
      lt2_r <= lt1_r;
      for (int i = 0; i < 3; i++) begin
        neg2_r[i] <= acc_c[i][AW-1];
        mag2_r[i] <= mag_c[i];
      end
      lt3_r  <= lt2_r;
      neg3_r <= neg2_r;
      mag3_r <= mag2_r;
      sh3_r  <= sh_c;
      mid4_r.lt  <= lt3_r;
      mid4_r.neg <= neg3_r;
      for (int i = 0; i < 3; i++) mid4_r.mag[i] <= shf_c[i][MAG_W-1:0];
    end
  end

  assign out_v   = v4_r;
  assign out_mid = mid4_r;

endmodule

/* rtl/core/ldvn_norm.sv */
// Length normalization: squares, sum, then a two-stage step per result bit.
// Depends on ldvn_pkg.
module ldvn_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  ldvn_pkg::mid_t    in_mid,
  output logic              out_v,
  output ldvn_pkg::light_t  out_lt
);
  import ldvn_pkg::*;

  logic                   va_r;
  light_t                 lta_r;
  logic [2:0]             nega_r;
  logic [2:0][SQ_W-1:0]   sq_r;

  logic                               v_q    [ITER_N+1];
  light_t                             lt_q   [ITER_N+1];
  logic [2:0]                         neg_q  [ITER_N+1];
  logic [SUM_W-1:0]                   s_q    [ITER_N+1];
  logic                               zs_q   [ITER_N+1];
  logic [2:0][RHS_W-1:0]              rhs_q  [ITER_N+1];
  logic [2:0][R_W-1:0]                r_q    [ITER_N+1];
  logic [2:0][RSQ_W-1:0]              r2_q   [ITER_N+1];

  logic [SUM_W-1:0]       s_c;
  logic                   vo_r;
  light_t                 lto_r;
  logic [2:0][7:0]        dir_c;

  assign s_c = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en) begin
      va_r   <= in_v;
      v_q[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lta_r  <= in_mid.lt;
      nega_r <= in_mid.neg;
      for (int i = 0; i < 3; i++) sq_r[i] <= SQ_W'(in_mid.mag[i]) * SQ_W'(in_mid.mag[i]);
      lt_q[0]  <= lta_r;
      neg_q[0] <= nega_r;
      s_q[0]   <= s_c;
      zs_q[0]  <= (s_c == '0);
      for (int i = 0; i < 3; i++) begin
        rhs_q[0][i] <= RHS_W'(sq_r[i]) * RHS_W'(LEN_SQ);
        r_q[0][i]   <= '0;
        r2_q[0][i]  <= '0;
      end
    end
  end

  for (genvar g = 0; g < ITER_N; g++) begin : g_it
    localparam int B = ITER_N - 1 - g;
    logic                  va_r2;
    light_t                lt_r;
    logic [2:0]            neg_r;
    logic [SUM_W-1:0]      s_r;
    logic                  zs_r;
    logic [2:0][RHS_W-1:0] rhs_r;
    logic [2:0][R_W-1:0]   r_r, c_r;
    logic [2:0][RSQ_W-1:0] r2_r, csq_r;
    logic [2:0]            ok_r;
    logic [2:0][PP_W-1:0]  lo_r, hi_r;
    logic [2:0][R_W-1:0]   c_c;
    logic [2:0][RSQ_W:0]   csq_c;
    logic [2:0]            take_c;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        c_c[i]   = r_q[g][i] | R_W'(1 << B);
        csq_c[i] = (RSQ_W+1)'(r2_q[g][i]) + ((RSQ_W+1)'(r_q[g][i]) << (B + 1))
                 + (RSQ_W+1)'(1 << (2 * B));
        take_c[i] = ok_r[i] &&
                    ((CMP_W'(lo_r[i]) + (CMP_W'(hi_r[i]) << HALF_W)) <= CMP_W'(rhs_r[i]));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r2    <= 1'b0;
        v_q[g+1] <= 1'b0;
      end else if (en) begin
        va_r2    <= v_q[g];
        v_q[g+1] <= va_r2;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lt_r  <= lt_q[g];
        neg_r <= neg_q[g];
        s_r   <= s_q[g];
        zs_r  <= zs_q[g];
        rhs_r <= rhs_q[g];
        r_r   <= r_q[g];
        r2_r  <= r2_q[g];
        for (int i = 0; i < 3; i++) begin
          c_r[i]   <= c_c[i];
          csq_r[i] <= csq_c[i][RSQ_W-1:0];
          ok_r[i]  <= (c_c[i] <= R_W'(OUT_LEN));
          lo_r[i]  <= PP_W'(csq_c[i][RSQ_W-1:0]) * PP_W'(s_q[g][HALF_W-1:0]);
          hi_r[i]  <= PP_W'(csq_c[i][RSQ_W-1:0]) * PP_W'(s_q[g][SUM_W-1:HALF_W]);
        end
        lt_q[g+1]  <= lt_r;
        neg_q[g+1] <= neg_r;
        s_q[g+1]   <= s_r;
        zs_q[g+1]  <= zs_r;
        rhs_q[g+1] <= rhs_r;
        for (int i = 0; i < 3; i++) begin
          r_q[g+1][i]  <= take_c[i] ? c_r[i] : r_r[i];
          r2_q[g+1][i] <= take_c[i] ? csq_r[i] : r2_r[i];
        end
      end
    end
  end

  always_comb begin
    dir_c = {lt_q[ITER_N].dz, lt_q[ITER_N].dy, lt_q[ITER_N].dx};
    if (lt_q[ITER_N].xf) begin
      for (int i = 0; i < 3; i++) begin
        dir_c[i] = zs_q[ITER_N] ? 8'd0 : neg_q[ITER_N][i] ?
                   8'(-{1'b0, r_q[ITER_N][i]}) : {1'b0, r_q[ITER_N][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_q[ITER_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lto_r.red   <= lt_q[ITER_N].red;
      lto_r.green <= lt_q[ITER_N].green;
      lto_r.blue  <= lt_q[ITER_N].blue;
      lto_r.xf    <= lt_q[ITER_N].xf;
      lto_r.dx    <= dir_c[0];
      lto_r.dy    <= dir_c[1];
      lto_r.dz    <= dir_c[2];
    end
  end

  assign out_v  = vo_r;
  assign out_lt = lto_r;

endmodule

/* rtl/core/ldvn_checker.sv */
// Port-level checks for the light direction view normalize top level.
// Bound to light_dir_view_normalize_top; no package dependency.
module ldvn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline stalled");

  a_free_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused with empty output");

endmodule

bind light_dir_view_normalize_top ldvn_checker u_ldvn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* verif/tb_light_dir_view_normalize_top.sv */
// Self-checking bench for light_dir_view_normalize_top: drives light records and
// matrix writes, predicts each result (direction rotated and normalized if xf is set)
// and checks every result. Depends on ldvn_pkg and the block's top module.
`timescale 1ns / 100ps

module tb_light_dir_view_normalize_top;
  import ldvn_pkg::*;

  localparam int EB = MATRIX_ELEM_BITS_DEF;
  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_data = '0;

  light_t lights_due[$];
  logic [ROW_W-1:0] view_rows [3];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int hold_off = 0;
  int stall_left = 0;

  light_dir_view_normalize_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic light_t rotate_normalize(light_t l);
    longint signed acc [3];
    longint unsigned mag [3];
    bit neg [3];
    longint unsigned mx, s, rhs, r, c, b;
    int sh;
    light_t o;
    o = l;
    if (l.xf) begin
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        acc[i] = longint'($signed(l.dx)) * longint'($signed(view_rows[0][i*EB +: EB]))
               + longint'($signed(l.dy)) * longint'($signed(view_rows[1][i*EB +: EB]))
               + longint'($signed(l.dz)) * longint'($signed(view_rows[2][i*EB +: EB]));
        neg[i] = acc[i] < 0;
        mag[i] = neg[i] ? longint'(-acc[i]) : longint'(acc[i]);
        if (mag[i] > mx) mx = mag[i];
      end
      sh = 0;
      while ((mx >> sh) >= 64'd16777216) sh++;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = mag[i] >> sh;
        s += mag[i] * mag[i];
      end
      for (int i = 0; i < 3; i++) begin
        r = 0;
        if (s != 0) begin
          rhs = 64'd14400 * mag[i] * mag[i];
          for (b = 64; b != 0; b = b >> 1) begin
            c = r | b;
            if (c <= 120 && c * c * s <= rhs) r = c;
          end
        end
        if (neg[i]) r = -r;
        case (i)
          0: o.dx = r[7:0];
          1: o.dy = r[7:0];
          default: o.dz = r[7:0];
        endcase
      end
    end
    return o;
  endfunction

  task automatic send_light(light_t l);
    in_tvalid <= 1'b1;
    in_tdata <= {l.dz, l.dy, l.dx, l.blue, l.green, l.red};
    in_tuser <= l.xf;
    do @(posedge clk); while (!in_tready);
    lights_due.push_back(rotate_normalize(l));
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic xf,
                             logic [7:0] x, logic [7:0] y, logic [7:0] z);
    light_t l;
    l = '{red: r, green: g, blue: b, xf: xf, dx: x, dy: y, dz: z};
    send_light(l);
  endtask

  task automatic send_random(int n);
    light_t l;
    for (int k = 0; k < n; k++) begin
      l = light_t'({$urandom, $urandom});
      if ($urandom_range(0, 3) != 0) l.xf = 1'b1;
      send_light(l);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (lights_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROW0: view_rows[0] = value;
      REG_ROW1: view_rows[1] = value;
      REG_ROW2: view_rows[2] = value;
      default: ;
    endcase
  endtask

  task automatic load_matrix(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                             logic [ROW_W-1:0] r2);
    drain();
    write_row(REG_ROW0, r0);
    write_row(REG_ROW1, r1);
    write_row(REG_ROW2, r2);
  endtask

  function automatic logic [ROW_W-1:0] rand_row(int kind);
    logic [ROW_W-1:0] v;
    case (kind)
      0: v = {$urandom, $urandom};
      1: v = {16'(($urandom_range(0, 1)) ? 16'h4000 : 16'hC000),
              16'($signed(6'($urandom))), 16'($signed(8'($urandom)))};
      2: v = {3{16'h7FFF}};
      3: v = {3{16'h8000}};
      default: v = '0;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    send_fields(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
    send_fields(8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h80, 8'h7F, 8'h80);
    send_fields(8'hFF, 8'h00, 8'hFF, 1'b0, 8'h7F, 8'h80, 8'h7F);
    send_fields(8'h12, 8'h34, 8'h56, 1'b1, 8'h00, 8'h00, 8'h00);
    send_fields(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h7F, 8'h00, 8'h00);
    send_fields(8'h01, 8'h02, 8'h03, 1'b1, 8'h80, 8'h80, 8'h80);
    send_fields(8'h80, 8'h40, 8'h20, 1'b1, 8'h7F, 8'h7F, 8'h7F);
    send_fields(8'hAA, 8'h55, 8'hAA, 1'b1, 8'h01, 8'hFF, 8'h00);
    send_fields(8'h55, 8'hAA, 8'h55, 1'b1, 8'h00, 8'h00, 8'h80);
    send_fields(8'h0F, 8'hF0, 8'h0F, 1'b1, 8'h03, 8'h04, 8'h00);
  endtask

  task automatic test_matrix_extremes();
    load_matrix('0, '0, '0);
    send_fields(8'h11, 8'h22, 8'h33, 1'b1, 8'h7F, 8'h80, 8'h05);
    send_fields(8'h11, 8'h22, 8'h33, 1'b0, 8'h7F, 8'h80, 8'h05);
    load_matrix({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    send_fields(8'h01, 8'h01, 8'h01, 1'b1, 8'h7F, 8'h7F, 8'h7F);
    send_fields(8'h01, 8'h01, 8'h01, 1'b1, 8'h80, 8'h7F, 8'h01);
    load_matrix({3{16'h8000}}, {3{16'hFFFF}}, {48{1'b1}});
    send_fields(8'h02, 8'h02, 8'h02, 1'b1, 8'h80, 8'h80, 8'h80);
    send_fields(8'h02, 8'h02, 8'h02, 1'b1, 8'h7F, 8'h00, 8'h80);
    drain();
    write_row(2'd3, {$urandom, $urandom});
    send_fields(8'h03, 8'h03, 8'h03, 1'b1, 8'h40, 8'hC0, 8'h20);
    load_matrix(ROW0_RST, ROW1_RST, ROW2_RST);
  endtask

  task automatic test_backpressure();
    drain();
    hold_off = 80;
    send_random(60);
  endtask

  task automatic test_random();
    for (int p = 0; p < 14; p++) begin
      load_matrix(rand_row($urandom_range(0, 4)), rand_row($urandom_range(0, 4)),
                  rand_row($urandom_range(0, 4)));
      if ($urandom_range(0, 7) == 0) write_row(2'd3, {$urandom, $urandom});
      send_random(50);
    end
    load_matrix(rand_row(1), rand_row(1), rand_row(1));
    quiet = 1'b1;
    send_random(80);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    light_t got, want;
    if (out_tvalid && out_tready) begin
      got = '{red: out_tdata[7:0], green: out_tdata[15:8], blue: out_tdata[23:16],
              xf: 1'b0, dx: out_tdata[31:24], dy: out_tdata[39:32], dz: out_tdata[47:40]};
      if (lights_due.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        want = lights_due.pop_front();
        if (got.red !== want.red) begin
          $error("out_red expected %0d actual %0d", want.red, got.red); errors++;
        end
        if (got.green !== want.green) begin
          $error("out_green expected %0d actual %0d", want.green, got.green); errors++;
        end
        if (got.blue !== want.blue) begin
          $error("out_blue expected %0d actual %0d", want.blue, got.blue); errors++;
        end
        if (got.dx !== want.dx) begin
          $error("out_dir_x expected %0d actual %0d", $signed(want.dx), $signed(got.dx));
          errors++;
        end
        if (got.dy !== want.dy) begin
          $error("out_dir_y expected %0d actual %0d", $signed(want.dy), $signed(got.dy));
          errors++;
        end
        if (got.dz !== want.dz) begin
          $error("out_dir_z expected %0d actual %0d", $signed(want.dz), $signed(got.dz));
          errors++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    view_rows[0] = ROW0_RST;
    view_rows[1] = ROW1_RST;
    view_rows[2] = ROW2_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_matrix_extremes();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
